@@ rtl/stpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_pkg: shared types and codes for the stable priority task queue
// Action and status codes, controller state encoding and the command bundle
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_OUT_BITS = 5;

    localparam logic [ACTION_BITS-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage
`default_nettype wire

@@ rtl/stpq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_ctrl: queue sequencer
// Takes one item, runs it through the slot array, holds the result until taken
// ----------------------------------------------------------------------------
module stpq_ctrl
    import stpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register must be free before the slots move
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_goes_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("capture did not move to exec");
    a_execute_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid)
        else $error("execute without result");
    a_no_execute_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.execute)
        else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/stpq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_datapath: sorted slot array with parallel compare-and-shift
// Each slot compares itself with the new priority and keeps, takes the new
// entry, or takes a neighbor; slot 0 always holds the next entry to leave
// ----------------------------------------------------------------------------
module stpq_datapath
    import stpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_cmd_t                   cmd,
    input  wire logic [ACTION_BITS-1:0]    action,
    input  wire logic [PRIORITY_BITS-1:0]  priority_req,
    input  wire logic [TAG_BITS-1:0]       task_tag,
    output logic [STATUS_BITS-1:0]         status,
    output logic [PRIORITY_BITS-1:0]       out_priority,
    output logic [TAG_BITS-1:0]            out_tag,
    output logic [COUNT_OUT_BITS-1:0]      entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    logic [ACTION_BITS-1:0]   act_reg;
    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [TAG_BITS-1:0]      tag_reg;

    logic [PRIORITY_BITS-1:0] slot_pri_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      slot_tag_reg [QUEUE_DEPTH];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic [STATUS_BITS-1:0]    status_reg;
    logic [PRIORITY_BITS-1:0]  out_pri_reg;
    logic [TAG_BITS-1:0]       out_tag_reg;
    logic [COUNT_OUT_BITS-1:0] out_cnt_reg;

    logic [QUEUE_DEPTH-1:0] keep;
    logic                   do_push;
    logic                   do_pop;
    logic                   is_full;
    logic                   is_empty;

    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);
    assign do_push  = cmd.execute && (act_reg == ACT_PUSH) && !is_full;
    assign do_pop   = cmd.execute && (act_reg == ACT_POP) && !is_empty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            pri_reg <= priority_req;
            tag_reg <= task_tag;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                     left_keep;
        logic [PRIORITY_BITS-1:0] left_pri;
        logic [TAG_BITS-1:0]      left_tag;
        logic [PRIORITY_BITS-1:0] right_pri;
        logic [TAG_BITS-1:0]      right_tag;
        logic [PRIORITY_BITS-1:0] pri_next;
        logic [TAG_BITS-1:0]      tag_next;

        // held entries with priority <= new one stay; they form a prefix
        assign keep[i] = (CW'(i) < count_reg) && (slot_pri_reg[i] <= pri_reg);

        if (i == 0)
        begin : g_head
            assign left_keep = 1'b1;
            assign left_pri  = slot_pri_reg[i];
            assign left_tag  = slot_tag_reg[i];
        end
        else
        begin : g_body
            assign left_keep = keep[i-1];
            assign left_pri  = slot_pri_reg[i-1];
            assign left_tag  = slot_tag_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_pri = slot_pri_reg[i];
            assign right_tag = slot_tag_reg[i];
        end
        else
        begin : g_inner
            assign right_pri = slot_pri_reg[i+1];
            assign right_tag = slot_tag_reg[i+1];
        end

        always_comb
        begin
            pri_next = slot_pri_reg[i];
            tag_next = slot_tag_reg[i];
            if (do_push && !keep[i])
            begin
                if (left_keep)
                begin
                    pri_next = pri_reg;
                    tag_next = tag_reg;
                end
                else
                begin
                    pri_next = left_pri;
                    tag_next = left_tag;
                end
            end
            else if (do_pop)
            begin
                pri_next = right_pri;
                tag_next = right_tag;
            end
        end

        always_ff @(posedge clk)
        begin
            slot_pri_reg[i] <= pri_next;
            slot_tag_reg[i] <= tag_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.execute)
        begin
            case (act_reg)
                ACT_PUSH:  count_next = is_full ? count_reg : count_reg + 1'b1;
                ACT_POP:   count_next = is_empty ? count_reg : count_reg - 1'b1;
                ACT_CLEAR: count_next = '0;
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg  <= STATUS_DONE;
            out_pri_reg <= '0;
            out_tag_reg <= '0;
            out_cnt_reg <= COUNT_OUT_BITS'(count_next);
            case (act_reg)
                ACT_PUSH:
                begin
                    if (is_full)
                    begin
                        status_reg <= STATUS_FULL;
                    end
                end
                ACT_POP:
                begin
                    if (is_empty)
                    begin
                        status_reg <= STATUS_EMPTY;
                    end
                    else
                    begin
                        out_pri_reg <= slot_pri_reg[0];
                        out_tag_reg <= slot_tag_reg[0];
                    end
                end
                ACT_CLEAR:
                begin
                    // clear reports how many entries were dropped
                    out_cnt_reg <= COUNT_OUT_BITS'(count_reg);
                end
                default:
                begin
                    out_cnt_reg <= COUNT_OUT_BITS'(count_reg);
                end
            endcase
        end
    end

    assign status       = status_reg;
    assign out_priority = out_pri_reg;
    assign out_tag      = out_tag_reg;
    assign entry_count  = out_cnt_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");
    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not remove one entry");
    a_push_increments: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not add one entry");
    a_idle_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(count_reg))
        else $error("count moved without an item");
`endif

endmodule
`default_nettype wire

@@ rtl/stable_priority_task_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_task_queue_core: bounded priority queue of tasks
// Push, pop-smallest and clear on a sorted slot array; equal priorities FIFO
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request item: tuser is the action (push, pop, clear),
//   tdata the priority and task tag. m_* returns exactly one result item per
//   request: tuser is the status, tdata the popped priority and tag and the
//   entry count.
//   an item is taken in the idle step and its slot update and result register
//   load happen in the execute step, which waits while an unaccepted result
//   holds the result register; the result is valid once loaded. the two-step
//   sequencer takes no new item until the current one has executed.
//   all slots compare against the new priority at once, so push and pop
//   cost the same at any depth.
//   when the receiver stalls, the result holds in the output register; the
//   next request is taken but waits in its execute step until the result
//   register is free.
//   reset empties the queue (count to zero); slot contents are not cleared,
//   and no clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_priority_task_queue_core
    import stpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // priority_req, task_tag, zero pad
    input  wire logic [((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  wire logic [ACTION_BITS-1:0] s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_priority, out_tag, entry_count, zero pad
    output logic [((PRIORITY_BITS + TAG_BITS + COUNT_OUT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [STATUS_BITS-1:0]     m_tuser
);

    localparam int IN_W      = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int OUT_USED  = PRIORITY_BITS + TAG_BITS + COUNT_OUT_BITS;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;

    dp_cmd_t                   cmd;
    logic [PRIORITY_BITS-1:0]  out_priority;
    logic [TAG_BITS-1:0]       out_tag;
    logic [COUNT_OUT_BITS-1:0] entry_count;

    stpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    stpq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (s_tuser),
        .priority_req (s_tdata[PRIORITY_BITS-1:0]),
        .task_tag     (s_tdata[PRIORITY_BITS + TAG_BITS - 1:PRIORITY_BITS]),
        .status       (m_tuser),
        .out_priority (out_priority),
        .out_tag      (out_tag),
        .entry_count  (entry_count)
    );

    assign m_tdata = OUT_W'({entry_count, out_tag, out_priority});

    // pad bits of s_tdata above the tag are ignored
    if (IN_W > PRIORITY_BITS + TAG_BITS)
    begin : g_pad
        logic unused_pad;
        assign unused_pad = ^s_tdata[IN_W-1:PRIORITY_BITS + TAG_BITS];
    end

endmodule
`default_nettype wire
